>>> hdl/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Operation codes, pipeline stage type, permutation and S-box tables, and the
// round function used by the round cells.
// ----------------------------------------------------------------------------
package des_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2
  } des_op_t;

  localparam int unsigned KEY_W   = 48;
  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned ROUNDS  = 16;
  localparam int unsigned SLOT_W  = 4;

  typedef struct packed {
    logic              valid;
    logic              dec;
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
  } des_stage_t;

  localparam logic [6:0] PERM_IP [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] PERM_FP [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] PERM_E [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] PERM_P [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd0,  4'd4,  4'd15, 4'd13, 4'd7,  4'd1,  4'd4,
      4'd2,  4'd14, 4'd15, 4'd2,  4'd11, 4'd13, 4'd8,  4'd1,
      4'd3,  4'd10, 4'd10, 4'd6,  4'd6,  4'd12, 4'd12, 4'd11,
      4'd5,  4'd9,  4'd9,  4'd5,  4'd0,  4'd3,  4'd7,  4'd8,
      4'd4,  4'd15, 4'd1,  4'd12, 4'd14, 4'd8,  4'd8,  4'd2,
      4'd13, 4'd4,  4'd6,  4'd9,  4'd2,  4'd1,  4'd11, 4'd7,
      4'd15, 4'd5,  4'd12, 4'd11, 4'd9,  4'd3,  4'd7,  4'd14,
      4'd3,  4'd10, 4'd10, 4'd0,  4'd5,  4'd6,  4'd0,  4'd13},
    '{4'd15, 4'd3,  4'd1,  4'd13, 4'd8,  4'd4,  4'd14, 4'd7,
      4'd6,  4'd15, 4'd11, 4'd2,  4'd3,  4'd8,  4'd4,  4'd14,
      4'd9,  4'd12, 4'd7,  4'd0,  4'd2,  4'd1,  4'd13, 4'd10,
      4'd12, 4'd6,  4'd0,  4'd9,  4'd5,  4'd11, 4'd10, 4'd5,
      4'd0,  4'd13, 4'd14, 4'd8,  4'd7,  4'd10, 4'd11, 4'd1,
      4'd10, 4'd3,  4'd4,  4'd15, 4'd13, 4'd4,  4'd1,  4'd2,
      4'd5,  4'd11, 4'd8,  4'd6,  4'd12, 4'd7,  4'd6,  4'd12,
      4'd9,  4'd0,  4'd3,  4'd5,  4'd2,  4'd14, 4'd15, 4'd9},
    '{4'd10, 4'd13, 4'd0,  4'd7,  4'd9,  4'd0,  4'd14, 4'd9,
      4'd6,  4'd3,  4'd3,  4'd4,  4'd15, 4'd6,  4'd5,  4'd10,
      4'd1,  4'd2,  4'd13, 4'd8,  4'd12, 4'd5,  4'd7,  4'd14,
      4'd11, 4'd12, 4'd4,  4'd11, 4'd2,  4'd15, 4'd8,  4'd1,
      4'd13, 4'd1,  4'd6,  4'd10, 4'd4,  4'd13, 4'd9,  4'd0,
      4'd8,  4'd6,  4'd15, 4'd9,  4'd3,  4'd8,  4'd0,  4'd7,
      4'd11, 4'd4,  4'd1,  4'd15, 4'd2,  4'd14, 4'd12, 4'd3,
      4'd5,  4'd11, 4'd10, 4'd5,  4'd14, 4'd2,  4'd7,  4'd12},
    '{4'd7,  4'd13, 4'd13, 4'd8,  4'd14, 4'd11, 4'd3,  4'd5,
      4'd0,  4'd6,  4'd6,  4'd15, 4'd9,  4'd0,  4'd10, 4'd3,
      4'd1,  4'd4,  4'd2,  4'd7,  4'd8,  4'd2,  4'd5,  4'd12,
      4'd11, 4'd1,  4'd12, 4'd10, 4'd4,  4'd14, 4'd15, 4'd9,
      4'd10, 4'd3,  4'd6,  4'd15, 4'd9,  4'd0,  4'd0,  4'd6,
      4'd12, 4'd10, 4'd11, 4'd1,  4'd7,  4'd13, 4'd13, 4'd8,
      4'd15, 4'd9,  4'd1,  4'd4,  4'd3,  4'd5,  4'd14, 4'd11,
      4'd5,  4'd12, 4'd2,  4'd7,  4'd8,  4'd2,  4'd4,  4'd14},
    '{4'd2,  4'd14, 4'd12, 4'd11, 4'd4,  4'd2,  4'd1,  4'd12,
      4'd7,  4'd4,  4'd10, 4'd7,  4'd11, 4'd13, 4'd6,  4'd1,
      4'd8,  4'd5,  4'd5,  4'd0,  4'd3,  4'd15, 4'd15, 4'd10,
      4'd13, 4'd3,  4'd0,  4'd9,  4'd14, 4'd8,  4'd9,  4'd6,
      4'd4,  4'd11, 4'd2,  4'd8,  4'd1,  4'd12, 4'd11, 4'd7,
      4'd10, 4'd1,  4'd13, 4'd14, 4'd7,  4'd2,  4'd8,  4'd13,
      4'd15, 4'd6,  4'd9,  4'd15, 4'd12, 4'd0,  4'd5,  4'd9,
      4'd6,  4'd10, 4'd3,  4'd4,  4'd0,  4'd5,  4'd14, 4'd3},
    '{4'd12, 4'd10, 4'd1,  4'd15, 4'd10, 4'd4,  4'd15, 4'd2,
      4'd9,  4'd7,  4'd2,  4'd12, 4'd6,  4'd9,  4'd8,  4'd5,
      4'd0,  4'd6,  4'd13, 4'd1,  4'd3,  4'd13, 4'd4,  4'd14,
      4'd14, 4'd0,  4'd7,  4'd11, 4'd5,  4'd3,  4'd11, 4'd8,
      4'd9,  4'd4,  4'd14, 4'd3,  4'd15, 4'd2,  4'd5,  4'd12,
      4'd2,  4'd9,  4'd8,  4'd5,  4'd12, 4'd15, 4'd3,  4'd10,
      4'd7,  4'd11, 4'd0,  4'd14, 4'd4,  4'd1,  4'd10, 4'd7,
      4'd1,  4'd6,  4'd13, 4'd0,  4'd11, 4'd8,  4'd6,  4'd13},
    '{4'd4,  4'd13, 4'd11, 4'd0,  4'd2,  4'd11, 4'd14, 4'd7,
      4'd15, 4'd4,  4'd0,  4'd9,  4'd8,  4'd1,  4'd13, 4'd10,
      4'd3,  4'd14, 4'd12, 4'd3,  4'd9,  4'd5,  4'd7,  4'd12,
      4'd5,  4'd2,  4'd10, 4'd15, 4'd6,  4'd8,  4'd1,  4'd6,
      4'd1,  4'd6,  4'd4,  4'd11, 4'd11, 4'd13, 4'd13, 4'd8,
      4'd12, 4'd1,  4'd3,  4'd4,  4'd7,  4'd10, 4'd14, 4'd7,
      4'd10, 4'd9,  4'd15, 4'd5,  4'd6,  4'd0,  4'd8,  4'd15,
      4'd0,  4'd14, 4'd5,  4'd2,  4'd9,  4'd3,  4'd2,  4'd12},
    '{4'd13, 4'd1,  4'd2,  4'd15, 4'd8,  4'd13, 4'd4,  4'd8,
      4'd6,  4'd10, 4'd15, 4'd3,  4'd11, 4'd7,  4'd1,  4'd4,
      4'd10, 4'd12, 4'd9,  4'd5,  4'd3,  4'd6,  4'd14, 4'd11,
      4'd5,  4'd0,  4'd0,  4'd14, 4'd12, 4'd9,  4'd7,  4'd2,
      4'd7,  4'd2,  4'd11, 4'd1,  4'd4,  4'd14, 4'd1,  4'd7,
      4'd9,  4'd4,  4'd12, 4'd10, 4'd14, 4'd8,  4'd2,  4'd13,
      4'd0,  4'd15, 4'd6,  4'd12, 4'd10, 4'd9,  4'd13, 4'd0,
      4'd15, 4'd3,  4'd3,  4'd5,  4'd5,  4'd6,  4'd8,  4'd11}
  };

  function automatic logic [BLOCK_W-1:0] perm_ip(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    logic [5:0]         idx;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(64 - int'(PERM_IP[i]));
      r[63-i] = v[idx];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_fp(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    logic [5:0]         idx;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(64 - int'(PERM_FP[i]));
      r[63-i] = v[idx];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] feistel(input logic [HALF_W-1:0] half,
                                               input logic [KEY_W-1:0]  key);
    logic [KEY_W-1:0]  x;
    logic [HALF_W-1:0] s;
    logic [HALF_W-1:0] p;
    logic [4:0]        idx;
    logic [5:0]        six;
    x = '0;
    s = '0;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      idx = 5'(32 - int'(PERM_E[i]));
      x[47-i] = half[idx];
    end
    x = x ^ key;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][six];
    end
    for (int i = 0; i < 32; i++) begin
      idx = 5'(32 - int'(PERM_P[i]));
      p[31-i] = s[idx];
    end
    return p;
  endfunction

endpackage

>>> hdl/des_block_cipher.sv
// ----------------------------------------------------------------------------
// DES block cipher
// ECB DES on 64-bit blocks with a sixteen-entry round-key store.
// ----------------------------------------------------------------------------
// A block request enters a chain of sixteen round cells, one round per cell,
// and one block may enter every cycle while the chain advances; its result
// leaves through the output register after the last cell. The chain stalls as a
// whole while the output register holds an untaken result. A key-load request
// writes one round key and is held off until every round cell is empty, so
// blocks always see the keys stored before they arrived. Reset clears all
// sixteen round keys to zero. Operation code three is accepted and dropped.
module des_block_cipher
  import des_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // key_slot[3:0], round_key[51:4], data_block[115:52], zero
  input  logic [1:0]   in_tuser,  // operation[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata  // result_block[63:0]
);

  logic [KEY_W-1:0]   keys_r [ROUNDS];
  des_stage_t         chain [ROUNDS+1];
  logic [ROUNDS-1:0]  busy_vec;
  logic               advance;
  logic               accept;
  logic               busy;
  des_op_t            op;
  logic [SLOT_W-1:0]  key_slot;
  logic [KEY_W-1:0]   round_key;
  logic [BLOCK_W-1:0] data_block;
  logic [BLOCK_W-1:0] ip_block;
  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_data_r;

  assign op         = des_op_t'(in_tuser);
  assign key_slot   = in_tdata[3:0];
  assign round_key  = in_tdata[51:4];
  assign data_block = in_tdata[115:52];

  assign advance = !out_valid_r || out_tready;
  assign busy    = |busy_vec;

  always_comb begin
    unique case (op)
      OP_LOAD: in_tready = !busy;
      default: in_tready = advance;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROUNDS; i++) begin
        keys_r[i] <= '0;
      end
    end else if (accept && op == OP_LOAD) begin
      keys_r[key_slot] <= round_key;
    end
  end

  always_comb begin
    ip_block       = perm_ip(data_block);
    chain[0].valid = accept && (op == OP_ENCRYPT || op == OP_DECRYPT);
    chain[0].dec   = (op == OP_DECRYPT);
    chain[0].l     = ip_block[63:32];
    chain[0].r     = ip_block[31:0];
  end

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    des_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .stage_in  (chain[g]),
      .key_enc   (keys_r[g]),
      .key_dec   (keys_r[ROUNDS-1-g]),
      .stage_out (chain[g+1])
    );
    assign busy_vec[g] = chain[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= perm_fp({chain[ROUNDS].r, chain[ROUNDS].l});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/des_round_cell.sv
// ----------------------------------------------------------------------------
// DES round cell
// One Feistel round with its own stage register; hands the swapped halves to
// the next cell whenever the chain advances.
// ----------------------------------------------------------------------------
module des_round_cell
  import des_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  des_stage_t        stage_in,
  input  logic [KEY_W-1:0]  key_enc,
  input  logic [KEY_W-1:0]  key_dec,
  output des_stage_t        stage_out
);

  des_stage_t       stage_r;
  des_stage_t       stage_nxt;
  logic [KEY_W-1:0] key_sel;

  always_comb begin
    key_sel         = stage_in.dec ? key_dec : key_enc;
    stage_nxt.valid = stage_in.valid;
    stage_nxt.dec   = stage_in.dec;
    stage_nxt.l     = stage_in.r;
    stage_nxt.r     = stage_in.l ^ feistel(stage_in.r, key_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (advance) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule
